### src/bpfa_pkg.sv
// shared constants and codes for the bitmap page frame allocator
`timescale 1ns / 1ps
package bpfa_pkg;

    localparam int NUM_FRAMES_DEF  = 65536;
    localparam int FRAME_BYTES_DEF = 4096;

    localparam int CMD_W    = 2;
    localparam int ADDR_W   = 28;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 17;

    localparam logic [CFG_W-1:0] FRAME_COUNT_RST = 17'd65536;

    localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESERVE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NONE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

endpackage

### src/bpfa_req_if.sv
// request and response channel interfaces
`timescale 1ns / 1ps
interface bpfa_req_if;
    logic                          valid;
    logic                          ready;
    logic [bpfa_pkg::CMD_W-1:0]    command;
    logic [bpfa_pkg::ADDR_W-1:0]   address;

    modport source (output valid, output command, output address, input ready);
    modport sink   (input valid, input command, input address, output ready);
endinterface

interface bpfa_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [bpfa_pkg::ADDR_W-1:0]   frame_address;
    logic [bpfa_pkg::STATUS_W-1:0] status;

    modport source (output valid, output frame_address, output status, input ready);
    modport sink   (input valid, input frame_address, input status, output ready);
endinterface

### src/bitmap_page_frame_allocator.sv
// bitmap page frame allocator: first-fit allocate, free and reserve over a bitmap memory
// in-range free and reserve do an RMW; out-of-range and unused commands skip to finish;
// allocate scans 64-frame words one per cycle through the read port, below
// min(frame_count, NUM_FRAMES) floored to a multiple of 8; one request at a time, the
// next accepted the cycle after the response loads; response register holds one; after
// reset, a clearing pass writes all-ones over (NUM_FRAMES+63)/64 words, one per cycle
`timescale 1ns / 1ps
module bitmap_page_frame_allocator #(
    parameter int NUM_FRAMES  = bpfa_pkg::NUM_FRAMES_DEF,
    parameter int FRAME_BYTES = bpfa_pkg::FRAME_BYTES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [bpfa_pkg::CFG_W-1:0] i_cfg_wdata,
    bpfa_req_if.sink                   i_req,
    bpfa_rsp_if.source                 o_rsp
);

    localparam int FBL   = $clog2(FRAME_BYTES);
    localparam int WORDS = (NUM_FRAMES + 63) / 64;
    localparam int WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CW    = $clog2(NUM_FRAMES) + 1;
    localparam int AFW   = bpfa_pkg::ADDR_W - FBL;
    localparam int LW0   = (CW > AFW) ? CW : AFW;
    localparam int LW1   = (LW0 > WW + 7) ? LW0 : WW + 7;
    localparam int LW    = (LW1 > bpfa_pkg::CFG_W) ? LW1 : bpfa_pkg::CFG_W;

    localparam logic [2:0] S_CLEAR    = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_DISPATCH = 3'd2;
    localparam logic [2:0] S_SCAN     = 3'd3;
    localparam logic [2:0] S_RMW      = 3'd4;
    localparam logic [2:0] S_FINISH   = 3'd5;

    logic [63:0] r_bitmap [WORDS];
    logic [63:0] r_rdata;

    logic [2:0]                    r_state, n_state;
    logic [WW-1:0]                 r_clr_idx, n_clr_idx;
    logic [WW:0]                   r_rd_idx, n_rd_idx;
    logic [WW-1:0]                 r_chk_idx, n_chk_idx;
    logic                          r_chk_v, n_chk_v;
    logic [bpfa_pkg::CFG_W-1:0]    r_frame_count;
    logic [bpfa_pkg::CMD_W-1:0]    r_cmd;
    logic [bpfa_pkg::ADDR_W-1:0]   r_addr;
    logic [bpfa_pkg::ADDR_W-1:0]   r_res_faddr, n_res_faddr;
    logic [bpfa_pkg::STATUS_W-1:0] r_res_status, n_res_status;
    logic                          r_out_valid;
    logic [bpfa_pkg::ADDR_W-1:0]   r_out_faddr;
    logic [bpfa_pkg::STATUS_W-1:0] r_out_status;

    logic          mem_we;
    logic [WW-1:0] mem_waddr;
    logic [63:0]   mem_wdata;
    logic [WW-1:0] mem_raddr;

    logic [LW-1:0]    cfg_ext, eff_count, limit, rd_base, chk_base, rem, req_frame;
    logic [LW-1:0]    found_frame;
    logic [LW+FBL-1:0] found_byte;
    logic [63:0]      mask, avail, rmw_bit;
    logic [5:0]       pos;
    logic             issue_ok, in_range, req_fire, finish_go;

    // effective frame count and search limit
    always_comb begin
        cfg_ext   = LW'(r_frame_count);
        eff_count = (cfg_ext > LW'(NUM_FRAMES)) ? LW'(NUM_FRAMES) : cfg_ext;
        limit     = {eff_count[LW-1:3], 3'b000};
        rd_base   = LW'({r_rd_idx, 6'b000000});
        chk_base  = LW'({r_chk_idx, 6'b000000});
        issue_ok  = rd_base < limit;
        rem       = limit - chk_base;
        if (rem >= LW'(64)) begin
            mask = '1;
        end else begin
            mask = (64'd1 << rem[5:0]) - 64'd1;
        end
        avail = ~r_rdata & mask;
        pos   = '0;
        for (int k = 63; k >= 0; k--) begin
            if (avail[k]) begin
                pos = 6'(k);
            end
        end
        found_frame = chk_base | LW'(pos);
        found_byte  = (LW + FBL)'(found_frame) << FBL;
        req_frame   = LW'(r_addr[bpfa_pkg::ADDR_W-1:FBL]);
        in_range    = req_frame < eff_count;
        rmw_bit     = 64'd1 << req_frame[5:0];
    end

    assign req_fire  = i_req.valid && i_req.ready;
    assign finish_go = !r_out_valid || o_rsp.ready;

    always_comb begin
        n_state      = r_state;
        n_clr_idx    = r_clr_idx;
        n_rd_idx     = r_rd_idx;
        n_chk_idx    = r_chk_idx;
        n_chk_v      = r_chk_v;
        n_res_faddr  = r_res_faddr;
        n_res_status = r_res_status;
        mem_we       = 1'b0;
        mem_waddr    = r_chk_idx;
        mem_wdata    = r_rdata;
        mem_raddr    = r_rd_idx[WW-1:0];
        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_idx;
                mem_wdata = '1;
                n_clr_idx = r_clr_idx + WW'(1);
                if (r_clr_idx == WW'(WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (req_fire) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                mem_raddr    = req_frame[6 +: WW];
                n_res_faddr  = '0;
                n_res_status = bpfa_pkg::ST_DONE;
                n_rd_idx     = '0;
                n_chk_v      = 1'b0;
                case (r_cmd)
                    bpfa_pkg::CMD_ALLOC: begin
                        n_state = S_SCAN;
                    end
                    bpfa_pkg::CMD_FREE, bpfa_pkg::CMD_RESERVE: begin
                        if (in_range) begin
                            n_state = S_RMW;
                        end else begin
                            n_res_status = bpfa_pkg::ST_RANGE;
                            n_state      = S_FINISH;
                        end
                    end
                    default: begin
                        n_state = S_FINISH;
                    end
                endcase
            end
            S_SCAN: begin
                if (r_chk_v && (avail != '0)) begin
                    mem_we       = 1'b1;
                    mem_waddr    = r_chk_idx;
                    mem_wdata    = r_rdata | (64'd1 << pos);
                    n_res_faddr  = found_byte[bpfa_pkg::ADDR_W-1:0];
                    n_res_status = bpfa_pkg::ST_DONE;
                    n_state      = S_FINISH;
                end else if (!issue_ok) begin
                    n_res_faddr  = '0;
                    n_res_status = bpfa_pkg::ST_NONE;
                    n_state      = S_FINISH;
                end else begin
                    n_chk_idx = r_rd_idx[WW-1:0];
                    n_chk_v   = 1'b1;
                    n_rd_idx  = r_rd_idx + (WW + 1)'(1);
                end
            end
            S_RMW: begin
                mem_we    = 1'b1;
                mem_waddr = req_frame[6 +: WW];
                if (r_cmd == bpfa_pkg::CMD_FREE) begin
                    mem_wdata = r_rdata & ~rmw_bit;
                end else begin
                    mem_wdata = r_rdata | rmw_bit;
                end
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (finish_go) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // bitmap memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_bitmap[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_bitmap[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr_idx     <= '0;
            r_chk_v       <= 1'b0;
            r_frame_count <= bpfa_pkg::FRAME_COUNT_RST;
            r_out_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_idx <= n_clr_idx;
            r_chk_v   <= n_chk_v;
            if (i_cfg_we) begin
                r_frame_count <= i_cfg_wdata;
            end
            if (r_state == S_FINISH && finish_go) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx     <= n_rd_idx;
        r_chk_idx    <= n_chk_idx;
        r_res_faddr  <= n_res_faddr;
        r_res_status <= n_res_status;
        if (req_fire) begin
            r_cmd  <= i_req.command;
            r_addr <= i_req.address;
        end
        if (r_state == S_FINISH && finish_go) begin
            r_out_faddr  <= r_res_faddr;
            r_out_status <= r_res_status;
        end
    end

    assign i_req.ready         = (r_state == S_IDLE);
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.frame_address = r_out_faddr;
    assign o_rsp.status        = r_out_status;

endmodule

### bench/testbench.sv
// self-checking testbench for the bitmap page frame allocator
`timescale 1ns / 1ps
module testbench;

    localparam int NUM_FRAMES  = bpfa_pkg::NUM_FRAMES_DEF;
    localparam int FRAME_BYTES = bpfa_pkg::FRAME_BYTES_DEF;
    localparam int WORDS       = (NUM_FRAMES + 63) / 64;

    localparam int CMD_W    = bpfa_pkg::CMD_W;
    localparam int ADDR_W   = bpfa_pkg::ADDR_W;
    localparam int STATUS_W = bpfa_pkg::STATUS_W;
    localparam int CFG_W    = bpfa_pkg::CFG_W;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int PHASES           = 10;
    localparam int ITEMS_PER_PHASE  = 40;
    localparam int SETTLE_CYCLES    = 20;

    typedef struct packed {
        logic [ADDR_W-1:0]   frame_address;
        logic [STATUS_W-1:0] status;
    } t_alloc_rsp;

    class frame_alloc_model;
        logic [63:0]      used_words [WORDS];
        logic [CFG_W-1:0] frame_count;
        t_alloc_rsp       pending_rsps[$];
        int               mismatches;
        int               grants;
        int               responses;

        function void reset_state();
            foreach (used_words[w]) used_words[w] = '1;
            frame_count = bpfa_pkg::FRAME_COUNT_RST;
            mismatches  = 0;
            grants      = 0;
            responses   = 0;
        endfunction

        function int unsigned managed_frames();
            if (frame_count > NUM_FRAMES) return NUM_FRAMES;
            return frame_count;
        endfunction

        function void note_request(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr);
            int unsigned count;
            int unsigned limit;
            int unsigned frame;
            int unsigned base;
            logic [63:0] avail;
            bit          found;
            t_alloc_rsp  rsp;
            count  = managed_frames();
            rsp    = '{frame_address: '0, status: bpfa_pkg::ST_DONE};
            found  = 0;
            frame  = 0;
            case (cmd)
                bpfa_pkg::CMD_ALLOC: begin
                    limit = (count / 8) * 8;
                    for (int w = 0; w < WORDS && w * 64 < limit && !found; w++) begin
                        base  = w * 64;
                        avail = ~used_words[w];
                        if (limit - base < 64) avail &= (64'd1 << (limit - base)) - 64'd1;
                        for (int k = 0; k < 64; k++) begin
                            if (!found && avail[k]) begin
                                found = 1;
                                frame = base + k;
                            end
                        end
                    end
                    if (found) begin
                        used_words[frame / 64][frame % 64] = 1'b1;
                        rsp.frame_address = ADDR_W'(frame * FRAME_BYTES);
                        grants++;
                    end else begin
                        rsp.status = bpfa_pkg::ST_NONE;
                    end
                end
                bpfa_pkg::CMD_FREE, bpfa_pkg::CMD_RESERVE: begin
                    frame = addr / FRAME_BYTES;
                    if (frame >= count) begin
                        rsp.status = bpfa_pkg::ST_RANGE;
                    end else begin
                        used_words[frame / 64][frame % 64] = (cmd == bpfa_pkg::CMD_RESERVE);
                    end
                end
                default: ;
            endcase
            pending_rsps.push_back(rsp);
        endfunction

        function void check_response(logic [ADDR_W-1:0] faddr, logic [STATUS_W-1:0] st);
            t_alloc_rsp want;
            responses++;
            if (pending_rsps.size() == 0) begin
                $error("response with no request outstanding: frame_address %0h status %0d",
                       faddr, st);
                mismatches++;
                return;
            end
            want = pending_rsps.pop_front();
            if (faddr !== want.frame_address) begin
                $error("frame_address: expected %0h actual %0h", want.frame_address, faddr);
                mismatches++;
            end
            if (st !== want.status) begin
                $error("status: expected %0d actual %0d", want.status, st);
                mismatches++;
            end
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_wdata;

    bpfa_req_if req_ch ();
    bpfa_rsp_if rsp_ch ();

    bitmap_page_frame_allocator uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    frame_alloc_model allocator = new();

    bit sender_calm;
    int requests_sent;
    int settings_used;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr);
        int gap;
        gap = sender_calm ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.command <= cmd;
        req_ch.address <= addr;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        allocator.note_request(cmd, addr);
        requests_sent++;
    endtask

    task automatic drain_responses();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (allocator.pending_rsps.size() != 0) @(posedge i_clk);
    endtask

    task automatic change_frame_count(input logic [CFG_W-1:0] value);
        drain_responses();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        allocator.frame_count = value;
        settings_used++;
    endtask

    function automatic logic [ADDR_W-1:0] pick_address(int unsigned count);
        int unsigned frame;
        int          sel;
        sel = $urandom_range(0, 99);
        if (count == 0 || sel < 15) return ADDR_W'($urandom);
        if (sel < 30) begin
            frame = (count < NUM_FRAMES) ? count + $urandom_range(0, 15)
                                         : $urandom_range(0, NUM_FRAMES - 1);
        end else if (sel < 65) begin
            frame = $urandom_range(0, ((count < 64) ? count : 64) - 1);
        end else begin
            frame = $urandom_range(0, count - 1);
        end
        return ADDR_W'(frame * FRAME_BYTES + $urandom_range(0, FRAME_BYTES - 1));
    endfunction

    function automatic logic [CMD_W-1:0] pick_command();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 38) return bpfa_pkg::CMD_ALLOC;
        if (sel < 73) return bpfa_pkg::CMD_FREE;
        if (sel < 93) return bpfa_pkg::CMD_RESERVE;
        return CMD_UNUSED;
    endfunction

    initial begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        int          stall;
        int          stretch_left;
        bit          quiet;
        stretch_left = 0;
        quiet        = 0;
        forever begin
            if (stretch_left == 0) begin
                quiet        = ($urandom_range(0, 2) == 0);
                stretch_left = $urandom_range(10, 40);
            end
            stall = quiet ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (rsp_ch.valid !== 1'b1);
            allocator.check_response(rsp_ch.frame_address, rsp_ch.status);
            stretch_left--;
        end
    end

    initial begin
        logic [CFG_W-1:0] phase_counts [PHASES];
        phase_counts = '{17'd65536, 17'd64, 17'd200, 17'd7, 17'd1000,
                         17'd131071, 17'd1, 17'd65535, 17'd8, 17'd4096};
        allocator.reset_state();
        requests_sent  = 0;
        settings_used  = 0;
        sender_calm    = 0;
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_wdata    <= '0;
        req_ch.valid   <= 1'b0;
        req_ch.command <= bpfa_pkg::CMD_ALLOC;
        req_ch.address <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: full range
        change_frame_count(bpfa_pkg::FRAME_COUNT_RST);
        send_request(bpfa_pkg::CMD_ALLOC, '0);
        send_request(bpfa_pkg::CMD_FREE, '0);
        send_request(bpfa_pkg::CMD_ALLOC, 28'h1234567);
        send_request(bpfa_pkg::CMD_FREE, 28'hFFFFFFF);
        send_request(bpfa_pkg::CMD_ALLOC, '0);
        send_request(bpfa_pkg::CMD_FREE, 28'h0005FFF);
        send_request(bpfa_pkg::CMD_RESERVE, 28'h0005000);
        send_request(bpfa_pkg::CMD_ALLOC, '0);
        send_request(CMD_UNUSED, 28'hFFFFFFF);
        // partial last group
        change_frame_count(17'd13);
        send_request(bpfa_pkg::CMD_FREE, ADDR_W'(12 * FRAME_BYTES));
        send_request(bpfa_pkg::CMD_ALLOC, '0);
        send_request(bpfa_pkg::CMD_FREE, ADDR_W'(7 * FRAME_BYTES + 'hABC));
        send_request(bpfa_pkg::CMD_ALLOC, '0);
        send_request(bpfa_pkg::CMD_FREE, ADDR_W'(13 * FRAME_BYTES));
        send_request(bpfa_pkg::CMD_RESERVE, 28'hFFFFFFF);
        // count above bitmap size
        change_frame_count(17'd131071);
        send_request(bpfa_pkg::CMD_FREE, 28'hFFFFFFF);
        send_request(bpfa_pkg::CMD_ALLOC, '0);
        send_request(bpfa_pkg::CMD_RESERVE, 28'hFFFF000);
        // empty range
        change_frame_count(17'd0);
        send_request(bpfa_pkg::CMD_FREE, '0);
        send_request(bpfa_pkg::CMD_RESERVE, '0);
        send_request(bpfa_pkg::CMD_ALLOC, '0);

        for (int p = 0; p < PHASES; p++) begin
            change_frame_count(phase_counts[p]);
            sender_calm = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(0, 29) == 0) drain_responses();
                send_request(pick_command(), pick_address(allocator.managed_frames()));
            end
        end

        drain_responses();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("ran %0d requests over %0d frame count settings", requests_sent,
                 settings_used);
        $display("%0d responses checked, %0d frames granted", allocator.responses,
                 allocator.grants);
        if (allocator.mismatches == 0 && allocator.pending_rsps.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
